/* sv/ssrc_pkg.sv */
// ----------------------------------------------------------------------------
// ssrc_pkg
// Types and constants shared by the servo status reply checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ssrc_pkg;

  // Largest payload the frame length logic accepts
  localparam logic [7:0] MAX_PAYLOAD = 8'd249;

  // Frame constants
  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [7:0] LEN_EXTRA   = 8'd2;
  localparam logic [7:0] FRAME_EXTRA = 8'd6;

  // Byte positions inside a frame
  localparam logic [7:0] POS_ID     = 8'd2;
  localparam logic [7:0] POS_LENGTH = 8'd3;
  localparam logic [7:0] POS_STATUS = 8'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ID     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LEN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_LENGTH = 8'd3;

  // Verdict codes
  localparam logic [2:0] VERD_OK       = 3'd0;
  localparam logic [2:0] VERD_SHORT    = 3'd1;
  localparam logic [2:0] VERD_HEADER   = 3'd2;
  localparam logic [2:0] VERD_ID       = 3'd3;
  localparam logic [2:0] VERD_LENGTH   = 3'd4;
  localparam logic [2:0] VERD_CHECKSUM = 3'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       timeout;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_payload;
    logic       frame_done;
    logic [2:0] verdict;
    logic [7:0] servo_status;
  } out_item_t;

  typedef struct packed {
    logic [7:0] expected_id;
    logic       check_id;
    logic [7:0] payload_len;
    logic       check_length;
  } cfg_t;

endpackage

`default_nettype wire

/* sv/ssrc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ssrc_cfg_regs
// Configuration register file of the servo status reply checker.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrc_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [ssrc_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [7:0]                    wr_data,
  output ssrc_pkg::cfg_t                     cfg
);
  import ssrc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_EXPECTED_ID:  cfg_nxt.expected_id  = wr_data;
        CFG_CHECK_ID:     cfg_nxt.check_id     = wr_data[0];
        CFG_PAYLOAD_LEN:  cfg_nxt.payload_len  = wr_data;
        CFG_CHECK_LENGTH: cfg_nxt.check_length = wr_data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_id  <= 8'd1;
      cfg_r.check_id     <= 1'b1;
      cfg_r.payload_len  <= 8'd0;
      cfg_r.check_length <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* sv/servo_status_reply_checker.sv */
// ----------------------------------------------------------------------------
// servo_status_reply_checker
// Byte-wise checker for a servo status reply frame.
// ----------------------------------------------------------------------------
// Each accepted item is one received byte (or a timeout marker). Items pass
// through an input register, combinational frame checking and an output
// register. A result is loaded into the output register when its item leaves
// the input register, which waits while out_stall holds the output. A new item
// is taken every cycle unless the input register is full and the output
// register is held by out_stall. Payload bytes come out as they arrive. The last
// byte of a frame (position payload_len+5, payload_len capped at 249) or a
// timeout yields a frame_done item with the verdict. Header, ID, length and
// status bytes give no result. Configuration writes are taken at any time
// (cfg_ready is always high) but must only be made while the checker is idle.
`default_nettype none

module servo_status_reply_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input items
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire ssrc_pkg::in_item_t             in_data,
  // result items
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output ssrc_pkg::out_item_t                 out_data,
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ssrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data
);
  import ssrc_pkg::*;

  cfg_t cfg;

  ssrc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign cfg_ready = 1'b1;

  // Input stage
  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_item_r;

  // Frame state
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       hdr_good_r, hdr_good_nxt;
  logic       id_good_r, id_good_nxt;
  logic       len_good_r, len_good_nxt;
  logic [7:0] status_r, status_nxt;

  // Output stage
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic       out_free;
  logic       advance;
  logic       in_take;
  logic [7:0] plen;
  logic [7:0] last_pos;
  logic [7:0] byte_in;
  logic       has_result;
  out_item_t  res;

  // Output register can load when empty or being emptied
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign byte_in  = s1_item_r.rx_byte;
  assign plen     = (cfg.payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : cfg.payload_len;
  assign last_pos = plen + FRAME_EXTRA - 8'd1;

  // Check one byte against the frame state
  always_comb begin
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    hdr_good_nxt = hdr_good_r;
    id_good_nxt  = id_good_r;
    len_good_nxt = len_good_r;
    status_nxt   = status_r;
    has_result   = 1'b0;
    res          = '0;

    if (advance) begin
      if (s1_item_r.timeout || (pos_r >= last_pos)) begin
        // End of frame: report verdict and restart
        has_result     = 1'b1;
        res.frame_done = 1'b1;
        if (s1_item_r.timeout) begin
          res.verdict = VERD_SHORT;
        end else if (!hdr_good_r) begin
          res.verdict = VERD_HEADER;
        end else if (!id_good_r) begin
          res.verdict = VERD_ID;
        end else if (!len_good_r) begin
          res.verdict = VERD_LENGTH;
        end else if (~sum_r != byte_in) begin
          res.verdict = VERD_CHECKSUM;
        end else begin
          res.verdict      = VERD_OK;
          res.servo_status = status_r;
        end
        pos_nxt      = 8'd0;
        sum_nxt      = 8'd0;
        hdr_good_nxt = 1'b1;
        id_good_nxt  = 1'b1;
        len_good_nxt = 1'b1;
        status_nxt   = 8'd0;
      end else begin
        pos_nxt = pos_r + 8'd1;
        if (pos_r < POS_ID) begin
          // Header bytes
          if (byte_in != HDR_BYTE) begin
            hdr_good_nxt = 1'b0;
          end
        end else begin
          sum_nxt = sum_r + byte_in;
          if (pos_r == POS_ID) begin
            if (cfg.check_id && (byte_in != cfg.expected_id)) begin
              id_good_nxt = 1'b0;
            end
          end else if (pos_r == POS_LENGTH) begin
            if (cfg.check_length && (byte_in != (plen + LEN_EXTRA))) begin
              len_good_nxt = 1'b0;
            end
          end else if (pos_r == POS_STATUS) begin
            status_nxt = byte_in;
          end else begin
            // Pass payload byte on
            has_result       = 1'b1;
            res.payload_byte = byte_in;
            res.is_payload   = 1'b1;
          end
        end
      end
    end
  end

  // Next values of the pipeline registers
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_free) begin
      out_valid_nxt = has_result;
      if (has_result) begin
        out_item_nxt = res;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= 8'd0;
      sum_r       <= 8'd0;
      hdr_good_r  <= 1'b1;
      id_good_r   <= 1'b1;
      len_good_r  <= 1'b1;
      status_r    <= 8'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      hdr_good_r  <= hdr_good_nxt;
      id_good_r   <= id_good_nxt;
      len_good_r  <= len_good_nxt;
      status_r    <= status_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Sends servo status replies byte by byte through the reply checker and
// compares every result item with a fixed table result or with a software
// copy of the frame checks. A short table of hand-made frames comes first.
// Random frames follow: good replies, replies with one fault, timeouts and
// line noise. Settings change between phases, sometimes in the middle of a
// frame. Both sides idle at random.
// ----------------------------------------------------------------------------

module testbench;
  import ssrc_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RANDOM_ITEMS = 1300;
  localparam int DIR_ROWS     = 25;

  typedef enum int {
    FR_GOOD, FR_HEADER, FR_ID, FR_LENGTH, FR_CHECKSUM, FR_TIMEOUT, FR_NOISE
  } frame_kind_t;

  // How a table row is checked: by the software checker, no result, or a verdict
  typedef enum int {ROW_MODEL, ROW_QUIET, ROW_VERDICT} row_kind_t;

  typedef struct {
    logic [7:0] rx_byte;
    logic       timeout;
    row_kind_t  kind;
    logic [2:0] verdict;
    logic [7:0] status;
  } dir_row_t;

  // Hand-made frames, read with payload_len 0, expected_id 1, both checks on
  dir_row_t dir_tab [DIR_ROWS] = '{
    // good reply, status byte all ones
    '{8'hFF, 1'b0, ROW_QUIET,   VERD_OK,       8'h00},
    '{8'hFF, 1'b0, ROW_QUIET,   VERD_OK,       8'h00},
    '{8'h01, 1'b0, ROW_QUIET,   VERD_OK,       8'h00},
    '{8'h02, 1'b0, ROW_QUIET,   VERD_OK,       8'h00},
    '{8'hFF, 1'b0, ROW_QUIET,   VERD_OK,       8'h00},
    '{8'hFD, 1'b0, ROW_VERDICT, VERD_OK,       8'hFF},
    // timeout with nothing received, byte ignored
    '{8'hFF, 1'b1, ROW_VERDICT, VERD_SHORT,    8'h00},
    // first header byte wrong
    '{8'h00, 1'b0, ROW_MODEL,   VERD_OK,       8'h00},
    '{8'hFF, 1'b0, ROW_MODEL,   VERD_OK,       8'h00},
    '{8'h01, 1'b0, ROW_MODEL,   VERD_OK,       8'h00},
    '{8'h02, 1'b0, ROW_MODEL,   VERD_OK,       8'h00},
    '{8'h00, 1'b0, ROW_MODEL,   VERD_OK,       8'h00},
    '{8'hFC, 1'b0, ROW_MODEL,   VERD_OK,       8'h00},
    // wrong ID and wrong length: ID is reported
    '{8'hFF, 1'b0, ROW_QUIET,   VERD_OK,       8'h00},
    '{8'hFF, 1'b0, ROW_QUIET,   VERD_OK,       8'h00},
    '{8'h00, 1'b0, ROW_QUIET,   VERD_OK,       8'h00},
    '{8'hFF, 1'b0, ROW_QUIET,   VERD_OK,       8'h00},
    '{8'h00, 1'b0, ROW_QUIET,   VERD_OK,       8'h00},
    '{8'h00, 1'b0, ROW_VERDICT, VERD_ID,       8'h00},
    // wrong checksum
    '{8'hFF, 1'b0, ROW_QUIET,   VERD_OK,       8'h00},
    '{8'hFF, 1'b0, ROW_QUIET,   VERD_OK,       8'h00},
    '{8'h01, 1'b0, ROW_QUIET,   VERD_OK,       8'h00},
    '{8'h02, 1'b0, ROW_QUIET,   VERD_OK,       8'h00},
    '{8'h00, 1'b0, ROW_QUIET,   VERD_OK,       8'h00},
    '{8'h00, 1'b0, ROW_VERDICT, VERD_CHECKSUM, 8'h00}
  };

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = '0;

  // Register copy, reset values
  logic [7:0] reg_expected_id  = 8'd1;
  logic       reg_check_id     = 1'b1;
  logic [7:0] reg_payload_len  = 8'd0;
  logic       reg_check_length = 1'b1;

  // Frame state of the software checker
  logic [7:0] fr_pos    = '0;
  logic [7:0] fr_sum    = '0;
  logic [7:0] fr_status = '0;
  logic       fr_hdr_ok = 1'b1;
  logic       fr_id_ok  = 1'b1;
  logic       fr_len_ok = 1'b1;

  out_item_t   pending_replies[$];
  in_item_t    frame_buf[$];
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned hold_left  = 0;
  bit          tx_quiet   = 1'b0;
  bit          rx_quiet   = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  servo_status_reply_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic in_item_t mk_item(input logic [7:0] b, input logic to);
    in_item_t it;
    it.rx_byte = b;
    it.timeout = to;
    return it;
  endfunction

  function automatic void restart_frame();
    fr_pos    = '0;
    fr_sum    = '0;
    fr_status = '0;
    fr_hdr_ok = 1'b1;
    fr_id_ok  = 1'b1;
    fr_len_ok = 1'b1;
  endfunction

  // Advance the frame checks by one item; return 1 when it yields a result
  function automatic bit next_reply_item(input in_item_t it, output out_item_t res);
    logic [7:0] plen;
    logic [7:0] last_pos;
    logic [7:0] pos;
    res      = '0;
    plen     = (reg_payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : reg_payload_len;
    last_pos = plen + FRAME_EXTRA - 8'd1;
    pos      = fr_pos;
    if (it.timeout) begin
      res.frame_done = 1'b1;
      res.verdict    = VERD_SHORT;
      restart_frame();
      return 1'b1;
    end
    // last byte: first failing check wins
    if (pos >= last_pos) begin
      res.frame_done = 1'b1;
      if (!fr_hdr_ok)
        res.verdict = VERD_HEADER;
      else if (!fr_id_ok)
        res.verdict = VERD_ID;
      else if (!fr_len_ok)
        res.verdict = VERD_LENGTH;
      else if (~fr_sum != it.rx_byte)
        res.verdict = VERD_CHECKSUM;
      else begin
        res.verdict      = VERD_OK;
        res.servo_status = fr_status;
      end
      restart_frame();
      return 1'b1;
    end
    fr_pos = pos + 8'd1;
    if (pos < POS_ID) begin
      if (it.rx_byte != HDR_BYTE) fr_hdr_ok = 1'b0;
      return 1'b0;
    end
    fr_sum = fr_sum + it.rx_byte;
    if (pos == POS_ID) begin
      if (reg_check_id && it.rx_byte != reg_expected_id) fr_id_ok = 1'b0;
      return 1'b0;
    end
    if (pos == POS_LENGTH) begin
      if (reg_check_length && it.rx_byte != plen + LEN_EXTRA) fr_len_ok = 1'b0;
      return 1'b0;
    end
    if (pos == POS_STATUS) begin
      fr_status = it.rx_byte;
      return 1'b0;
    end
    res.payload_byte = it.rx_byte;
    res.is_payload   = 1'b1;
    return 1'b1;
  endfunction

  // Fill frame_buf with one reply of the given kind for the current settings
  function automatic void build_frame(input frame_kind_t kind);
    logic [7:0] plen;
    logic [7:0] sum;
    logic [7:0] bytes[$];
    int         n;
    int         k;
    plen = (reg_payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : reg_payload_len;
    n    = int'(plen) + int'(FRAME_EXTRA);
    bytes.push_back(HDR_BYTE);
    bytes.push_back(HDR_BYTE);
    bytes.push_back(reg_check_id ? reg_expected_id : 8'($urandom));
    bytes.push_back(reg_check_length ? plen + LEN_EXTRA : 8'($urandom));
    for (k = 4; k < n - 1; k++) bytes.push_back(8'($urandom));
    sum = '0;
    for (k = 2; k < n - 1; k++) sum = sum + bytes[k];
    bytes.push_back(~sum);
    // inject one fault
    case (kind)
      FR_HEADER:   bytes[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      FR_ID:       bytes[POS_ID] ^= 8'($urandom_range(1, 255));
      FR_LENGTH:   bytes[POS_LENGTH] ^= 8'($urandom_range(1, 255));
      FR_CHECKSUM: bytes[n - 1] ^= 8'($urandom_range(1, 255));
      FR_NOISE: begin
        bytes.delete();
        repeat ($urandom_range(1, 2 * n)) bytes.push_back(8'($urandom));
      end
      default: ;
    endcase
    frame_buf.delete();
    foreach (bytes[i]) frame_buf.push_back(mk_item(bytes[i], 1'b0));
    // cut short by a line timeout, which also brings the checker back in step
    if (kind == FR_TIMEOUT || kind == FR_NOISE) begin
      k = $urandom_range(0, frame_buf.size() - 1);
      while (frame_buf.size() > k) void'(frame_buf.pop_back());
      frame_buf.push_back(mk_item(8'($urandom), 1'b1));
    end
  endfunction

  function automatic frame_kind_t pick_kind();
    if ($urandom_range(0, 9) < 6) return FR_GOOD;
    return frame_kind_t'($urandom_range(int'(FR_HEADER), int'(FR_NOISE)));
  endfunction

  function automatic void log_failure(input string what, input out_item_t want,
                                      input out_item_t got);
    fail_count++;
    if (fail_count <= 10)
      $display({"%0t %s: want pb=%h pl=%b done=%b v=%0d st=%h,",
                " got pb=%h pl=%b done=%b v=%0d st=%h"},
               $time, what, want.payload_byte, want.is_payload, want.frame_done,
               want.verdict, want.servo_status, got.payload_byte, got.is_payload,
               got.frame_done, got.verdict, got.servo_status);
  endfunction

  // Send one item after a random gap; queue its expected result on acceptance
  task automatic send_item(input in_item_t it, input bit fixed = 1'b0,
                           input bit fixed_has = 1'b0, input out_item_t fixed_res = '0);
    int unsigned gap;
    out_item_t   res;
    bit          has;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    has = next_reply_item(it, res);
    if (fixed) begin
      has = fixed_has;
      res = fixed_res;
    end
    if (has) pending_replies.push_back(res);
    items_sent++;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_EXPECTED_ID:  reg_expected_id  = val;
      CFG_CHECK_ID:     reg_check_id     = val[0];
      CFG_PAYLOAD_LEN:  reg_payload_len  = val;
      CFG_CHECK_LENGTH: reg_check_length = val[0];
      default: ;
    endcase
  endtask

  // Hold the sender until every expected result is out and the pipe is empty
  task automatic quiesce();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_replies.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // New settings for a phase; early phases hit the extremes
  task automatic configure(input int phase);
    logic [7:0] eid;
    logic [7:0] plen;
    eid = 8'($urandom);
    if (phase == 1) eid = 8'h00;
    else if (phase == 2) eid = 8'hFF;
    plen = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 12));
    if (phase == 3) plen = MAX_PAYLOAD;
    else if (phase == 7) plen = 8'hFF;
    if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(CFG_EXPECTED_ID, eid);
    if (phase == 0 || $urandom_range(0, 3) != 0)
      write_reg(CFG_CHECK_ID, {7'($urandom), 1'($urandom)});
    write_reg(CFG_PAYLOAD_LEN, plen);
    if (phase == 0 || $urandom_range(0, 3) != 0)
      write_reg(CFG_CHECK_LENGTH, {7'($urandom), 1'($urandom)});
    // index past the register list is dropped by the block
    if ($urandom_range(0, 5) == 0)
      write_reg(CFG_IDX_W'($urandom_range(4, 255)), 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Check result items in order and draw the stall before the next one
  always @(posedge clk) begin : reply_monitor
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        want = '0;
        log_failure("unexpected item", want, out_data);
      end else begin
        want = pending_replies.pop_front();
        if (out_data.payload_byte !== want.payload_byte ||
            out_data.is_payload   !== want.is_payload   ||
            out_data.frame_done   !== want.frame_done   ||
            out_data.verdict      !== want.verdict      ||
            out_data.servo_status !== want.servo_status)
          log_failure("mismatch", want, out_data);
      end
      hold_left = rx_quiet ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : stimulus
    out_item_t fixed_res;
    int        phase;
    int        n_frames;
    int        k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the hand-made frames
    foreach (dir_tab[i]) begin
      fixed_res              = '0;
      fixed_res.frame_done   = 1'b1;
      fixed_res.verdict      = dir_tab[i].verdict;
      fixed_res.servo_status = dir_tab[i].status;
      send_item(mk_item(dir_tab[i].rx_byte, dir_tab[i].timeout),
                dir_tab[i].kind != ROW_MODEL, dir_tab[i].kind == ROW_VERDICT, fixed_res);
    end
    quiesce();

    // random phases
    items_sent = 0;
    phase      = 0;
    while (items_sent < RANDOM_ITEMS) begin
      configure(phase);
      // finish a frame left open across the change, then resync with a timeout
      if (frame_buf.size() != 0) begin
        while (frame_buf.size() != 0) send_item(frame_buf.pop_front());
        send_item(mk_item(8'($urandom), 1'b1));
      end
      n_frames = (reg_payload_len > 8'd100) ? 1 : $urandom_range(3, 10);
      repeat (n_frames) begin
        build_frame(pick_kind());
        while (frame_buf.size() != 0) send_item(frame_buf.pop_front());
      end
      // leave part of a good frame pending over the next settings change
      if ($urandom_range(0, 1) == 0) begin
        build_frame(FR_GOOD);
        k = $urandom_range(1, frame_buf.size() - 1);
        repeat (k) send_item(frame_buf.pop_front());
      end
      quiesce();
      phase++;
    end

    if (pending_replies.size() != 0) begin
      $display("%0d expected items never arrived", pending_replies.size());
      fail_count += pending_replies.size();
    end
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #(CLK_PERIOD * 600_000);
    $display("FAIL");
    $finish;
  end

endmodule
